// ===== sv/pca_pkg.sv =====
// shared types and constants for the pose compose accumulator
// no dependencies; imported by every module of the block
package pca_pkg;

   localparam int DATA_W = 32;
   localparam int UV_W   = 33;
   localparam int PROD_W = 65;
   localparam int TERM_W = 35;
   localparam int ACC_W  = 40;
   localparam int FRAC   = 30;
   localparam int PC_W   = 6;

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh4000_0000;

   typedef enum logic [1:0] {
      ASEL_X,
      ASEL_Y,
      ASEL_Z,
      ASEL_W
   } asel_type;

   typedef enum logic [3:0] {
      BSEL_V0,
      BSEL_V1,
      BSEL_V2,
      BSEL_B0,
      BSEL_B1,
      BSEL_B2,
      BSEL_B3,
      BSEL_UV0,
      BSEL_UV1,
      BSEL_UV2
   } bsel_type;

   typedef enum logic [3:0] {
      DST_UV0,
      DST_UV1,
      DST_UV2,
      DST_T0,
      DST_T1,
      DST_T2,
      DST_Q0,
      DST_Q1,
      DST_Q2,
      DST_Q3
   } dst_type;

   typedef enum logic {
      SEQ_NEXT,
      SEQ_COMMIT
   } seq_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic     mul;
      asel_type a_sel;
      bsel_type b_sel;
      logic     neg;
      logic     first;
      logic     last;
      dst_type  dst;
      seq_type  seq;
   } uword_type;

   typedef struct packed {
      logic     load;
      logic     issue;
      asel_type a_sel;
      bsel_type b_sel;
      logic     neg;
      logic     first;
      logic     last;
      dst_type  dst;
      logic     commit;
   } ctrl_type;

   localparam uword_type UWORD_NOP = '{
      mul: 1'b0, a_sel: ASEL_X, b_sel: BSEL_V0, neg: 1'b0, first: 1'b0,
      last: 1'b0, dst: DST_UV0, seq: SEQ_NEXT};

   localparam uword_type UWORD_COMMIT = '{
      mul: 1'b0, a_sel: ASEL_X, b_sel: BSEL_V0, neg: 1'b0, first: 1'b0,
      last: 1'b0, dst: DST_UV0, seq: SEQ_COMMIT};

endpackage

// ===== sv/pca_ucode_rom.sv =====
// microcode program: one control word per step of the pose update
// depends on pca_pkg
module pca_ucode_rom (
   input  logic [pca_pkg::PC_W-1:0] pc,
   output pca_pkg::uword_type       uword
);
   import pca_pkg::*;

   function automatic uword_type mk(asel_type a, bsel_type b, logic neg, logic first,
                                    logic last, dst_type dst);
      uword_type w;
      w.mul   = 1'b1;
      w.a_sel = a;
      w.b_sel = b;
      w.neg   = neg;
      w.first = first;
      w.last  = last;
      w.dst   = dst;
      w.seq   = SEQ_NEXT;
      return w;
   endfunction

   always_comb begin
      case (pc)
         // cross product u x v, doubled and clamped
         6'd0:  uword = mk(ASEL_Y, BSEL_V2,  1'b0, 1'b1, 1'b0, DST_UV0);
         6'd1:  uword = mk(ASEL_Z, BSEL_V1,  1'b1, 1'b0, 1'b1, DST_UV0);
         6'd2:  uword = mk(ASEL_Z, BSEL_V0,  1'b0, 1'b1, 1'b0, DST_UV1);
         6'd3:  uword = mk(ASEL_X, BSEL_V2,  1'b1, 1'b0, 1'b1, DST_UV1);
         6'd4:  uword = mk(ASEL_X, BSEL_V1,  1'b0, 1'b1, 1'b0, DST_UV2);
         6'd5:  uword = mk(ASEL_Y, BSEL_V0,  1'b1, 1'b0, 1'b1, DST_UV2);
         // rotated translation added onto stored translation
         6'd6:  uword = mk(ASEL_W, BSEL_UV0, 1'b0, 1'b1, 1'b0, DST_T0);
         6'd7:  uword = mk(ASEL_Y, BSEL_UV2, 1'b0, 1'b0, 1'b0, DST_T0);
         6'd8:  uword = mk(ASEL_Z, BSEL_UV1, 1'b1, 1'b0, 1'b1, DST_T0);
         6'd9:  uword = mk(ASEL_W, BSEL_UV1, 1'b0, 1'b1, 1'b0, DST_T1);
         6'd10: uword = mk(ASEL_Z, BSEL_UV0, 1'b0, 1'b0, 1'b0, DST_T1);
         6'd11: uword = mk(ASEL_X, BSEL_UV2, 1'b1, 1'b0, 1'b1, DST_T1);
         6'd12: uword = mk(ASEL_W, BSEL_UV2, 1'b0, 1'b1, 1'b0, DST_T2);
         6'd13: uword = mk(ASEL_X, BSEL_UV1, 1'b0, 1'b0, 1'b0, DST_T2);
         6'd14: uword = mk(ASEL_Y, BSEL_UV0, 1'b1, 1'b0, 1'b1, DST_T2);
         // hamilton product stored * increment
         6'd15: uword = mk(ASEL_W, BSEL_B0,  1'b0, 1'b1, 1'b0, DST_Q0);
         6'd16: uword = mk(ASEL_X, BSEL_B3,  1'b0, 1'b0, 1'b0, DST_Q0);
         6'd17: uword = mk(ASEL_Y, BSEL_B2,  1'b0, 1'b0, 1'b0, DST_Q0);
         6'd18: uword = mk(ASEL_Z, BSEL_B1,  1'b1, 1'b0, 1'b1, DST_Q0);
         6'd19: uword = mk(ASEL_W, BSEL_B1,  1'b0, 1'b1, 1'b0, DST_Q1);
         6'd20: uword = mk(ASEL_X, BSEL_B2,  1'b1, 1'b0, 1'b0, DST_Q1);
         6'd21: uword = mk(ASEL_Y, BSEL_B3,  1'b0, 1'b0, 1'b0, DST_Q1);
         6'd22: uword = mk(ASEL_Z, BSEL_B0,  1'b0, 1'b0, 1'b1, DST_Q1);
         6'd23: uword = mk(ASEL_W, BSEL_B2,  1'b0, 1'b1, 1'b0, DST_Q2);
         6'd24: uword = mk(ASEL_X, BSEL_B1,  1'b0, 1'b0, 1'b0, DST_Q2);
         6'd25: uword = mk(ASEL_Y, BSEL_B0,  1'b1, 1'b0, 1'b0, DST_Q2);
         6'd26: uword = mk(ASEL_Z, BSEL_B3,  1'b0, 1'b0, 1'b1, DST_Q2);
         6'd27: uword = mk(ASEL_W, BSEL_B3,  1'b0, 1'b1, 1'b0, DST_Q3);
         6'd28: uword = mk(ASEL_X, BSEL_B0,  1'b1, 1'b0, 1'b0, DST_Q3);
         6'd29: uword = mk(ASEL_Y, BSEL_B1,  1'b1, 1'b0, 1'b0, DST_Q3);
         6'd30: uword = mk(ASEL_Z, BSEL_B2,  1'b1, 1'b0, 1'b1, DST_Q3);
         // let the last product drain, then hand the pose over
         6'd31: uword = UWORD_NOP;
         6'd32: uword = UWORD_COMMIT;
         default: uword = UWORD_COMMIT;
      endcase
   end

endmodule

// ===== sv/pca_sequencer.sv =====
// step counter and control word issue for the pose update program
// depends on pca_pkg and pca_ucode_rom
module pca_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                out_free,
   output logic                req_stall,
   output pca_pkg::ctrl_type   ctrl
);
   import pca_pkg::*;

   state_type       state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uword;

   pca_ucode_rom u_rom (
      .pc    (pc_ff),
      .uword (uword)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      ctrl        = '0;
      ctrl.a_sel  = uword.a_sel;
      ctrl.b_sel  = uword.b_sel;
      ctrl.neg    = uword.neg;
      ctrl.first  = uword.first;
      ctrl.last   = uword.last;
      ctrl.dst    = uword.dst;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               ctrl.load = 1'b1;
               pc_in     = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            case (uword.seq)
               SEQ_NEXT: begin
                  ctrl.issue = uword.mul;
                  pc_in      = pc_ff + PC_W'(1);
               end
               SEQ_COMMIT: begin
                  // hold here while the output register is still occupied and rsp_stall is high
                  if (out_free) begin
                     ctrl.commit = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/pca_datapath.sv =====
// operand registers, shared multiplier, rounding accumulator and pose state
// depends on pca_pkg; driven by pca_sequencer control words
module pca_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pca_pkg::ctrl_type                    ctrl,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_tx,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_ty,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_tz,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_qx,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_qy,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_qz,
   input  logic signed [pca_pkg::DATA_W-1:0]    req_delta_qw,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_tx,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_ty,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_tz,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_qx,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_qy,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_qz,
   output logic signed [pca_pkg::DATA_W-1:0]    rsp_pose_qw
);
   import pca_pkg::*;

   localparam logic signed [ACC_W-1:0]  ACC_I32_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0]  ACC_I32_MIN = -ACC_W'(64'sd2147483648);
   localparam logic signed [ACC_W-1:0]  ACC_UV_HI   = ACC_W'(64'sd2147483648);
   localparam logic signed [ACC_W-1:0]  ACC_UV_LO   = -ACC_W'(64'sd2147483648);
   localparam logic signed [UV_W-1:0]   UV_MAX      = 33'sh0_FFFF_FFFF;
   localparam logic signed [UV_W-1:0]   UV_MIN      = 33'sh1_0000_0001;
   localparam logic signed [PROD_W-1:0] HALF_LSB    = PROD_W'(1) <<< (FRAC - 1);

   logic signed [DATA_W-1:0] v_ff [3], v_in [3];
   logic signed [DATA_W-1:0] b_ff [4], b_in [4];
   logic signed [UV_W-1:0]   uv_ff [3], uv_in [3];
   logic signed [DATA_W-1:0] t_ff [3], t_in [3];
   logic signed [DATA_W-1:0] q_ff [4], q_in [4];
   logic signed [DATA_W-1:0] qn_ff [4], qn_in [4];
   logic signed [DATA_W-1:0] out_ff [7], out_in [7];
   logic                     out_valid_ff, out_valid_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     ex_valid_ff, ex_valid_in;
   logic                     ex_neg_ff, ex_neg_in;
   logic                     ex_first_ff, ex_first_in;
   logic                     ex_last_ff, ex_last_in;
   dst_type                  ex_dst_ff, ex_dst_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [DATA_W-1:0] a_op;
   logic signed [UV_W-1:0]   b_op;
   logic signed [PROD_W-1:0] rnd;
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  acc_sum;

   function automatic logic signed [DATA_W-1:0] sat32(logic signed [ACC_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > ACC_I32_MAX) begin
         r = ACC_I32_MAX[DATA_W-1:0];
      end else if (x < ACC_I32_MIN) begin
         r = ACC_I32_MIN[DATA_W-1:0];
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // doubled cross product, clamped to plus or minus (2^32 - 1)
   function automatic logic signed [UV_W-1:0] sat_uv(logic signed [ACC_W-1:0] x);
      logic signed [UV_W-1:0] r;
      if (x >= ACC_UV_HI) begin
         r = UV_MAX;
      end else if (x <= ACC_UV_LO) begin
         r = UV_MIN;
      end else begin
         r = {x[DATA_W-1:0], 1'b0};
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff         <= '{default: '0};
         q_ff         <= '{'0, '0, '0, Q_ONE};
         out_valid_ff <= 1'b0;
         ex_valid_ff  <= 1'b0;
      end else begin
         t_ff         <= t_in;
         q_ff         <= q_in;
         out_valid_ff <= out_valid_in;
         ex_valid_ff  <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      b_ff        <= b_in;
      uv_ff       <= uv_in;
      qn_ff       <= qn_in;
      out_ff      <= out_in;
      prod_ff     <= prod_in;
      ex_neg_ff   <= ex_neg_in;
      ex_first_ff <= ex_first_in;
      ex_last_ff  <= ex_last_in;
      ex_dst_ff   <= ex_dst_in;
      acc_ff      <= acc_in;
   end

   // issue stage: operand select and multiply
   always_comb begin
      a_op = q_ff[ctrl.a_sel];
      case (ctrl.b_sel)
         BSEL_V0:  b_op = {v_ff[0][DATA_W-1], v_ff[0]};
         BSEL_V1:  b_op = {v_ff[1][DATA_W-1], v_ff[1]};
         BSEL_V2:  b_op = {v_ff[2][DATA_W-1], v_ff[2]};
         BSEL_B0:  b_op = {b_ff[0][DATA_W-1], b_ff[0]};
         BSEL_B1:  b_op = {b_ff[1][DATA_W-1], b_ff[1]};
         BSEL_B2:  b_op = {b_ff[2][DATA_W-1], b_ff[2]};
         BSEL_B3:  b_op = {b_ff[3][DATA_W-1], b_ff[3]};
         BSEL_UV0: b_op = uv_ff[0];
         BSEL_UV1: b_op = uv_ff[1];
         BSEL_UV2: b_op = uv_ff[2];
         default:  b_op = '0;
      endcase
      prod_in     = PROD_W'(a_op) * PROD_W'(b_op);
      ex_valid_in = ctrl.issue;
      ex_neg_in   = ctrl.neg;
      ex_first_in = ctrl.first;
      ex_last_in  = ctrl.last;
      ex_dst_in   = ctrl.dst;
   end

   // accumulate stage: round half up, add or subtract, write back on last term
   always_comb begin
      rnd  = prod_ff + HALF_LSB;
      term = rnd[PROD_W-1:FRAC];
      if (ex_first_ff) begin
         case (ex_dst_ff)
            DST_T0:  base = ACC_W'(t_ff[0]) + ACC_W'(v_ff[0]);
            DST_T1:  base = ACC_W'(t_ff[1]) + ACC_W'(v_ff[1]);
            DST_T2:  base = ACC_W'(t_ff[2]) + ACC_W'(v_ff[2]);
            default: base = '0;
         endcase
      end else begin
         base = acc_ff;
      end
      acc_sum = ex_neg_ff ? (base - ACC_W'(term)) : (base + ACC_W'(term));
      acc_in  = ex_valid_ff ? acc_sum : acc_ff;

      v_in   = v_ff;
      b_in   = b_ff;
      uv_in  = uv_ff;
      t_in   = t_ff;
      q_in   = q_ff;
      qn_in  = qn_ff;
      out_in = out_ff;

      if (ctrl.load) begin
         v_in[0] = req_delta_tx;
         v_in[1] = req_delta_ty;
         v_in[2] = req_delta_tz;
         b_in[0] = req_delta_qx;
         b_in[1] = req_delta_qy;
         b_in[2] = req_delta_qz;
         b_in[3] = req_delta_qw;
      end

      if (ex_valid_ff && ex_last_ff) begin
         case (ex_dst_ff)
            DST_UV0: uv_in[0] = sat_uv(acc_sum);
            DST_UV1: uv_in[1] = sat_uv(acc_sum);
            DST_UV2: uv_in[2] = sat_uv(acc_sum);
            DST_T0:  t_in[0]  = sat32(acc_sum);
            DST_T1:  t_in[1]  = sat32(acc_sum);
            DST_T2:  t_in[2]  = sat32(acc_sum);
            DST_Q0:  qn_in[0] = sat32(acc_sum);
            DST_Q1:  qn_in[1] = sat32(acc_sum);
            DST_Q2:  qn_in[2] = sat32(acc_sum);
            DST_Q3:  qn_in[3] = sat32(acc_sum);
            default: acc_in   = acc_sum;
         endcase
      end

      if (ctrl.commit) begin
         q_in      = qn_ff;
         out_in[0] = t_ff[0];
         out_in[1] = t_ff[1];
         out_in[2] = t_ff[2];
         out_in[3] = qn_ff[0];
         out_in[4] = qn_ff[1];
         out_in[5] = qn_ff[2];
         out_in[6] = qn_ff[3];
      end

      if (ctrl.commit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_pose_tx = out_ff[0];
   assign rsp_pose_ty = out_ff[1];
   assign rsp_pose_tz = out_ff[2];
   assign rsp_pose_qx = out_ff[3];
   assign rsp_pose_qy = out_ff[4];
   assign rsp_pose_qz = out_ff[5];
   assign rsp_pose_qw = out_ff[6];

endmodule

// ===== sv/pose_compose_accumulator_unit.sv =====
// top level of the pose compose accumulator: dead-reckoning pose update
// depends on pca_pkg, pca_sequencer and pca_datapath
//
//   channel   ports                                  direction   transfer when
//   req       req_valid, req_stall, req_delta_*      in          req_valid && !req_stall
//   rsp       rsp_valid, rsp_stall, rsp_pose_*       out         rsp_valid && !rsp_stall
//
// an item is taken with the transfer, then runs 31 steps through the single
// shared 32x33 multiplier, one step to drain its accumulate stage and one commit step
// the next item is taken while the previous pose still waits on rsp
// the commit step holds while the output register is full and rsp_stall is high
// synchronous reset restores identity pose and zero translation
module pose_compose_accumulator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_tx,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_ty,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_tz,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_qx,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_qy,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_qz,
   input  logic signed [pca_pkg::DATA_W-1:0] req_delta_qw,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_tx,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_ty,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_tz,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_qx,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_qy,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_qz,
   output logic signed [pca_pkg::DATA_W-1:0] rsp_pose_qw
);
   import pca_pkg::*;

   ctrl_type ctrl;
   logic     out_free;

   assign out_free = !rsp_valid || !rsp_stall;

   pca_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   pca_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_delta_tx (req_delta_tx),
      .req_delta_ty (req_delta_ty),
      .req_delta_tz (req_delta_tz),
      .req_delta_qx (req_delta_qx),
      .req_delta_qy (req_delta_qy),
      .req_delta_qz (req_delta_qz),
      .req_delta_qw (req_delta_qw),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_pose_tx  (rsp_pose_tx),
      .rsp_pose_ty  (rsp_pose_ty),
      .rsp_pose_tz  (rsp_pose_tz),
      .rsp_pose_qx  (rsp_pose_qx),
      .rsp_pose_qy  (rsp_pose_qy),
      .rsp_pose_qz  (rsp_pose_qz),
      .rsp_pose_qw  (rsp_pose_qw)
   );

endmodule

// ===== tb/sv/pose_compose_check_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the pose compose accumulator: running pose prediction and result checks
// depends on pca_pkg for the data width and the Q2.30 unit constant
package pose_compose_check_pkg;

   import pca_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] tx;
      logic signed [DATA_W-1:0] ty;
      logic signed [DATA_W-1:0] tz;
      logic signed [DATA_W-1:0] qx;
      logic signed [DATA_W-1:0] qy;
      logic signed [DATA_W-1:0] qz;
      logic signed [DATA_W-1:0] qw;
   } pose_type;

   localparam longint UV_LIMIT = 64'sd4294967295;
   localparam longint WORD_HI  = 64'sd2147483647;
   localparam longint WORD_LO  = -64'sd2147483648;

   class pose_scoreboard_type;
      longint   acc_t[3];
      longint   acc_q[4];
      pose_type awaited_poses[$];
      int       mismatches;
      int       increments_noted;
      int       poses_checked;

      function new();
         acc_t[0] = 0;
         acc_t[1] = 0;
         acc_t[2] = 0;
         acc_q[0] = 0;
         acc_q[1] = 0;
         acc_q[2] = 0;
         acc_q[3] = longint'(Q_ONE);
         mismatches = 0;
         increments_noted = 0;
         poses_checked = 0;
      endfunction

      // exact product, plus half an lsb, floored back to the target format
      function longint mul_round(longint a, longint b);
         logic signed [127:0] p;
         p = a * b + 128'sd536870912;
         return longint'(p >>> FRAC);
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function int pending();
         return awaited_poses.size();
      endfunction

      function void note_increment(pose_type inc);
         longint   v[3];
         longint   b[4];
         longint   c[3];
         longint   uv[3];
         longint   rot[3];
         longint   r[4];
         longint   ax, ay, az, aw;
         pose_type p;
         ax = acc_q[0];
         ay = acc_q[1];
         az = acc_q[2];
         aw = acc_q[3];
         v[0] = inc.tx;
         v[1] = inc.ty;
         v[2] = inc.tz;
         b[0] = inc.qx;
         b[1] = inc.qy;
         b[2] = inc.qz;
         b[3] = inc.qw;

         // translation rotated by the old orientation
         c[0] = mul_round(ay, v[2]) - mul_round(az, v[1]);
         c[1] = mul_round(az, v[0]) - mul_round(ax, v[2]);
         c[2] = mul_round(ax, v[1]) - mul_round(ay, v[0]);
         for (int i = 0; i < 3; i++)
            uv[i] = clamp(2 * c[i], -UV_LIMIT, UV_LIMIT);
         rot[0] = v[0] + mul_round(aw, uv[0]) + mul_round(ay, uv[2]) - mul_round(az, uv[1]);
         rot[1] = v[1] + mul_round(aw, uv[1]) + mul_round(az, uv[0]) - mul_round(ax, uv[2]);
         rot[2] = v[2] + mul_round(aw, uv[2]) + mul_round(ax, uv[1]) - mul_round(ay, uv[0]);
         for (int i = 0; i < 3; i++)
            acc_t[i] = clamp(acc_t[i] + rot[i], WORD_LO, WORD_HI);

         // hamilton product, stored times increment
         r[0] = mul_round(aw, b[0]) + mul_round(ax, b[3]) + mul_round(ay, b[2])
              - mul_round(az, b[1]);
         r[1] = mul_round(aw, b[1]) - mul_round(ax, b[2]) + mul_round(ay, b[3])
              + mul_round(az, b[0]);
         r[2] = mul_round(aw, b[2]) + mul_round(ax, b[1]) - mul_round(ay, b[0])
              + mul_round(az, b[3]);
         r[3] = mul_round(aw, b[3]) - mul_round(ax, b[0]) - mul_round(ay, b[1])
              - mul_round(az, b[2]);
         for (int i = 0; i < 4; i++)
            acc_q[i] = clamp(r[i], WORD_LO, WORD_HI);

         p.tx = 32'(acc_t[0]);
         p.ty = 32'(acc_t[1]);
         p.tz = 32'(acc_t[2]);
         p.qx = 32'(acc_q[0]);
         p.qy = 32'(acc_q[1]);
         p.qz = 32'(acc_q[2]);
         p.qw = 32'(acc_q[3]);
         awaited_poses = {awaited_poses, p};
         increments_noted++;
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch at pose %0d: %s", poses_checked, what);
      endtask

      task compare_field(string field, logic signed [DATA_W-1:0] got,
                         logic signed [DATA_W-1:0] want);
         if (got !== want)
            report($sformatf("%s got %0d expected %0d", field, got, want));
      endtask

      task check_pose(pose_type got);
         pose_type want;
         if (awaited_poses.size() == 0) begin
            report("pose transfer with nothing outstanding");
         end else begin
            want = awaited_poses.pop_front();
            compare_field("pose_tx", got.tx, want.tx);
            compare_field("pose_ty", got.ty, want.ty);
            compare_field("pose_tz", got.tz, want.tz);
            compare_field("pose_qx", got.qx, want.qx);
            compare_field("pose_qy", got.qy, want.qy);
            compare_field("pose_qz", got.qz, want.qz);
            compare_field("pose_qw", got.qw, want.qw);
         end
         poses_checked++;
      endtask
   endclass

endpackage

// ===== tb/sv/pose_compose_accumulator_unit_test.sv =====
`timescale 1ns / 1ps
// top-level testbench for pose_compose_accumulator_unit: stimulus, handshakes, checks
// depends on pca_pkg, pose_compose_check_pkg and the rtl of the block
module pose_compose_accumulator_unit_test;

   import pca_pkg::*;
   import pose_compose_check_pkg::*;

   localparam logic signed [DATA_W-1:0] WMAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] WMIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] S45  = 32'sd759250125;
   localparam logic signed [DATA_W-1:0] M1   = 32'sd65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DATA_W-1:0] req_delta_tx = '0;
   logic signed [DATA_W-1:0] req_delta_ty = '0;
   logic signed [DATA_W-1:0] req_delta_tz = '0;
   logic signed [DATA_W-1:0] req_delta_qx = '0;
   logic signed [DATA_W-1:0] req_delta_qy = '0;
   logic signed [DATA_W-1:0] req_delta_qz = '0;
   logic signed [DATA_W-1:0] req_delta_qw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_pose_tx;
   logic signed [DATA_W-1:0] rsp_pose_ty;
   logic signed [DATA_W-1:0] rsp_pose_tz;
   logic signed [DATA_W-1:0] rsp_pose_qx;
   logic signed [DATA_W-1:0] rsp_pose_qy;
   logic signed [DATA_W-1:0] rsp_pose_qz;
   logic signed [DATA_W-1:0] rsp_pose_qw;

   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   pose_scoreboard_type sb;

   pose_compose_accumulator_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_delta_tx (req_delta_tx),
      .req_delta_ty (req_delta_ty),
      .req_delta_tz (req_delta_tz),
      .req_delta_qx (req_delta_qx),
      .req_delta_qy (req_delta_qy),
      .req_delta_qz (req_delta_qz),
      .req_delta_qw (req_delta_qw),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pose_tx  (rsp_pose_tx),
      .rsp_pose_ty  (rsp_pose_ty),
      .rsp_pose_tz  (rsp_pose_tz),
      .rsp_pose_qx  (rsp_pose_qx),
      .rsp_pose_qy  (rsp_pose_qy),
      .rsp_pose_qz  (rsp_pose_qz),
      .rsp_pose_qw  (rsp_pose_qw)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pose(pose_type'{rsp_pose_tx, rsp_pose_ty, rsp_pose_tz,
                                  rsp_pose_qx, rsp_pose_qy, rsp_pose_qz, rsp_pose_qw});
   end

   task automatic send_increment(input pose_type inc);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_delta_tx <= inc.tx;
      req_delta_ty <= inc.ty;
      req_delta_tz <= inc.tz;
      req_delta_qx <= inc.qx;
      req_delta_qy <= inc.qy;
      req_delta_qz <= inc.qz;
      req_delta_qw <= inc.qw;
      do @(posedge clock); while (req_stall);
      sb.note_increment(inc);
   endtask

   function automatic logic signed [DATA_W-1:0] to_q30(real x);
      if (x >= 2.0) return WMAX;
      if (x < -2.0) return WMIN;
      return $rtoi(x * 1073741824.0);
   endfunction

   function automatic real rand_unit();
      return (real'($urandom) / 4294967296.0) * 2.0 - 1.0;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_span();
      return $signed($urandom) >>> $urandom_range(31);
   endfunction

   // well-formed frame step: unit rotation, often small, and a translation of random reach
   function automatic pose_type unit_rotation_step();
      real x, y, z, w, n;
      pose_type p;
      x = rand_unit();
      y = rand_unit();
      z = rand_unit();
      w = rand_unit();
      if ($urandom_range(1) == 1) begin
         x = x * 0.05;
         y = y * 0.05;
         z = z * 0.05;
         w = 1.0;
      end
      n = $sqrt(x * x + y * y + z * z + w * w);
      if (n < 1.0e-6) begin
         x = 0.0;
         y = 0.0;
         z = 0.0;
         w = 1.0;
         n = 1.0;
      end
      p.tx = rand_span();
      p.ty = rand_span();
      p.tz = rand_span();
      p.qx = to_q30(x / n);
      p.qy = to_q30(y / n);
      p.qz = to_q30(z / n);
      p.qw = to_q30(w / n);
      return p;
   endfunction

   // inverse of the tracked orientation, pulls the accumulated quaternion back near identity
   function automatic pose_type recenter_step();
      real x, y, z, w, n;
      pose_type p;
      x = real'(sb.acc_q[0]) / 1073741824.0;
      y = real'(sb.acc_q[1]) / 1073741824.0;
      z = real'(sb.acc_q[2]) / 1073741824.0;
      w = real'(sb.acc_q[3]) / 1073741824.0;
      n = x * x + y * y + z * z + w * w;
      if (n < 1.0e-9) begin
         x = 0.0;
         y = 0.0;
         z = 0.0;
         w = 1.0;
         n = 1.0;
      end
      p.tx = rand_span() >>> 8;
      p.ty = rand_span() >>> 8;
      p.tz = rand_span() >>> 8;
      p.qx = to_q30(-x / n);
      p.qy = to_q30(-y / n);
      p.qz = to_q30(-z / n);
      p.qw = to_q30(w / n);
      return p;
   endfunction

   task automatic run_random(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 8) begin
            send_increment(pose_type'{$urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom});
            send_increment(recenter_step());
         end else begin
            send_increment(unit_rotation_step());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: saturation, axis rotations, quaternion overflow, tiny values
      send_increment(pose_type'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{WMAX, WMAX, WMAX, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{32'sd1, 32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{WMIN, WMIN, WMIN, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{WMIN, WMIN, WMIN, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{WMAX, WMAX, WMAX, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{M1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, S45, S45});
      send_increment(pose_type'{M1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{32'sd0, M1, -M1, Q_ONE, 32'sd0, 32'sd0, 32'sd0});
      send_increment(pose_type'{-M1, 3 * M1, 32'sd0, 32'sd0, Q_ONE, 32'sd0, 32'sd0});
      send_increment(pose_type'{WMAX, WMIN, WMAX, WMAX, WMAX, WMAX, WMAX});
      send_increment(pose_type'{WMAX, WMIN, WMAX, 32'sd0, 32'sd0, 32'sd0, Q_ONE});
      send_increment(pose_type'{WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN});
      send_increment(pose_type'{WMIN, WMAX, WMIN, WMIN, WMAX, WMIN, WMAX});
      send_increment(recenter_step());
      send_increment(pose_type'{32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1, 32'sd1, Q_ONE});

      // long output hold-off while the sender keeps offering
      hold_left = 300;
      for (int k = 0; k < 24; k++)
         send_increment(unit_rotation_step());

      sender_gap_pct = 10;
      receiver_stall_pct = 88;
      run_random(600);
      sender_gap_pct = 88;
      receiver_stall_pct = 10;
      run_random(600);
      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      run_random(600);

      // stored rotation collapses to zero, after which translation passes unrotated
      send_increment(pose_type'{M1, -M1, M1, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
      send_increment(pose_type'{3 * M1, M1, -M1, S45, 32'sd0, 32'sd0, S45});
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      $display("summary: %0d increments sent, %0d poses checked, %0d mismatches",
               sb.increments_noted, sb.poses_checked, sb.mismatches);
      $display("summary: extremes, axis turns, overflow, hold-off and three idle mixes");
      if (sb.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
